@@ hw/rtl/tvsp_pkg.sv @@
// Shared types, codes and constants of the two-voice sample player.
// No dependencies; used by tvsp_front, tvsp_back and the top level.
package tvsp_pkg;

	// Sample memory geometry
	localparam int ROM_ADDR_BITS  = 19;
	localparam int ROM_DEPTH      = 1 << ROM_ADDR_BITS;
	localparam int FULL_ADDR_BITS = 19;

	// Input func codes
	localparam logic [1:0] FUNC_REG  = 2'd0;
	localparam logic [1:0] FUNC_LOAD = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	// Sample byte codes
	localparam logic [7:0] END_BYTE     = 8'hff;
	localparam logic [7:0] SILENCE_BYTE = 8'h00;
	localparam logic [7:0] BIAS_BYTE    = 8'h80;

	// Command queue between the front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_CW    = 3;

	typedef enum logic [1:0] {
		CMD_SEL,
		CMD_START,
		CMD_LOAD,
		CMD_TICK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic                      voice;
		logic [7:0]                data;
		logic [FULL_ADDR_BITS-1:0] addr;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	// Gain per index: 26, 84, 200, 258
	function automatic logic [8:0] gain_of(input logic [1:0] idx);
		logic [8:0] g;
		case (idx)
			2'd0: g = 9'd26;
			2'd1: g = 9'd84;
			2'd2: g = 9'd200;
			default: g = 9'd258;
		endcase
		return g;
	endfunction

endpackage

@@ hw/rtl/tvsp_front.sv @@
// Front end: accepts input beats, classifies them into commands and queues them.
// Depends on tvsp_pkg.
module tvsp_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [31:0]            s_tdata,   // reg_offset[1:0], data_byte[9:2], rom_address[28:10]
	input  logic [1:0]             s_tuser,   // func[1:0]
	input  logic                   pop,
	output tvsp_pkg::q_head_t      head
);

	tvsp_pkg::cmd_t                queue_q [tvsp_pkg::QUEUE_DEPTH];
	logic [tvsp_pkg::QUEUE_AW-1:0] wptr_q;
	logic [tvsp_pkg::QUEUE_AW-1:0] rptr_q;
	logic [tvsp_pkg::QUEUE_CW-1:0] count_q;
	tvsp_pkg::cmd_t                cmd;
	logic                          keep;
	logic                          push;
	logic                          do_pop;

	// Classify the beat; unused func codes are accepted and dropped
	always_comb begin
		cmd.voice = s_tdata[1];
		cmd.data  = s_tdata[9:2];
		cmd.addr  = s_tdata[28:10];
		keep      = 1'b1;
		case (s_tuser)
			tvsp_pkg::FUNC_REG:  cmd.kind = s_tdata[0] ? tvsp_pkg::CMD_SEL : tvsp_pkg::CMD_START;
			tvsp_pkg::FUNC_LOAD: cmd.kind = tvsp_pkg::CMD_LOAD;
			tvsp_pkg::FUNC_TICK: cmd.kind = tvsp_pkg::CMD_TICK;
			default: begin
				cmd.kind = tvsp_pkg::CMD_TICK;
				keep     = 1'b0;
			end
		endcase
	end

	assign s_tready   = (count_q != tvsp_pkg::QUEUE_CW'(tvsp_pkg::QUEUE_DEPTH));
	assign push       = s_tvalid && s_tready && keep;
	assign head.valid = (count_q != '0);
	assign head.cmd   = queue_q[rptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/tvsp_back.sv @@
// Back end: sample memory, voice state and the sequencer that runs queued commands.
// Depends on tvsp_pkg.
module tvsp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tvsp_pkg::q_head_t head,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata    // sample_a[15:0], sample_b[31:16]
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START_HI,
		ST_START_LO,
		ST_VOICE_CHK,
		ST_VOICE_BYTE,
		ST_VOICE_SIL,
		ST_OUT
	} state_t;

	state_t state_q;

	// Sample memory, single port
	logic [7:0]                          rom_mem [tvsp_pkg::ROM_DEPTH];
	logic [7:0]                          rd_q;
	logic                                rom_we;
	logic [tvsp_pkg::FULL_ADDR_BITS-1:0] rom_addr;

	// Voice state
	logic [7:0]  sel_q    [2];
	logic        active_q [2];
	logic [2:0]  bank_q   [2];
	logic [15:0] ptr_q    [2];
	logic [1:0]  gain_q   [2];
	logic [7:0]  sil_q    [2];
	logic [15:0] samp_q   [2];

	// Start command in flight
	logic        v_q;
	logic [4:0]  num_q;
	logic [2:0]  bank_pend_q;
	logic [1:0]  gain_pend_q;
	logic [7:0]  hi_q;
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;

	logic [7:0]         head_sel;
	logic [4:0]         head_num;
	logic signed [7:0]  centered;
	logic signed [17:0] prod;
	state_t             after_voice;

	assign head_sel    = sel_q[head.cmd.voice];
	assign head_num    = head_sel[4:0] - 5'd1;
	assign centered    = $signed(rd_q ^ tvsp_pkg::BIAS_BYTE);
	assign prod        = $signed({1'b0, tvsp_pkg::gain_of(gain_q[v_q])}) * centered;
	assign after_voice = v_q ? ST_OUT : ST_VOICE_CHK;
	assign m_tvalid    = m_tvalid_q;
	assign m_tdata     = m_tdata_q;

	// Memory address and command pop
	always_comb begin
		rom_we   = 1'b0;
		rom_addr = '0;
		pop      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop = head.valid;
				if (head.cmd.kind == tvsp_pkg::CMD_LOAD) begin
					rom_we   = head.valid;
					rom_addr = head.cmd.addr;
				end else begin
					rom_addr = {head_sel[7:5], 10'd0, head_num, 1'b0};
				end
			end
			ST_START_HI: rom_addr = {bank_pend_q, 10'd0, num_q, 1'b1};
			ST_VOICE_CHK, ST_VOICE_BYTE: rom_addr = {bank_q[v_q], ptr_q[v_q]};
			default: rom_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rom_we) begin
			rom_mem[rom_addr[tvsp_pkg::ROM_ADDR_BITS-1:0]] <= head.cmd.data;
		end else begin
			rd_q <= rom_mem[rom_addr[tvsp_pkg::ROM_ADDR_BITS-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			v_q         <= 1'b0;
			num_q       <= '0;
			bank_pend_q <= '0;
			gain_pend_q <= '0;
			hi_q        <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			for (int i = 0; i < 2; i++) begin
				sel_q[i]    <= '0;
				active_q[i] <= 1'b0;
				bank_q[i]   <= '0;
				ptr_q[i]    <= '0;
				gain_q[i]   <= '0;
				sil_q[i]    <= '0;
				samp_q[i]   <= '0;
			end
		end else begin
			// Drop valid once the beat is taken, unless ST_OUT reloads it
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						case (head.cmd.kind)
							tvsp_pkg::CMD_SEL: sel_q[head.cmd.voice] <= head.cmd.data;
							tvsp_pkg::CMD_START: begin
								if (head_sel[4:0] != '0) begin
									v_q         <= head.cmd.voice;
									num_q       <= head_num;
									bank_pend_q <= head_sel[7:5];
									gain_pend_q <= head.cmd.data[7:6];
									state_q     <= ST_START_HI;
								end
							end
							tvsp_pkg::CMD_TICK: begin
								v_q     <= 1'b0;
								state_q <= ST_VOICE_CHK;
							end
							default: ;
						endcase
					end
				end
				ST_START_HI: begin
					hi_q    <= rd_q;
					state_q <= ST_START_LO;
				end
				ST_START_LO: begin
					ptr_q[v_q]    <= {hi_q, rd_q};
					bank_q[v_q]   <= bank_pend_q;
					gain_q[v_q]   <= gain_pend_q;
					sil_q[v_q]    <= '0;
					active_q[v_q] <= 1'b1;
					state_q       <= ST_IDLE;
				end
				ST_VOICE_CHK: begin
					if (!active_q[v_q]) begin
						samp_q[v_q] <= '0;
						v_q         <= 1'b1;
						state_q     <= after_voice;
					end else if (sil_q[v_q] != '0) begin
						sil_q[v_q]  <= sil_q[v_q] - 8'd1;
						samp_q[v_q] <= '0;
						v_q         <= 1'b1;
						state_q     <= after_voice;
					end else begin
						ptr_q[v_q] <= ptr_q[v_q] + 16'd1;
						state_q    <= ST_VOICE_BYTE;
					end
				end
				ST_VOICE_BYTE: begin
					if (rd_q == tvsp_pkg::END_BYTE) begin
						active_q[v_q] <= 1'b0;
						samp_q[v_q]   <= '0;
						v_q           <= 1'b1;
						state_q       <= after_voice;
					end else if (rd_q == tvsp_pkg::SILENCE_BYTE) begin
						ptr_q[v_q] <= ptr_q[v_q] + 16'd1;
						state_q    <= ST_VOICE_SIL;
					end else begin
						samp_q[v_q] <= prod[15:0];
						v_q         <= 1'b1;
						state_q     <= after_voice;
					end
				end
				ST_VOICE_SIL: begin
					sil_q[v_q]  <= rd_q;
					samp_q[v_q] <= '0;
					v_q         <= 1'b1;
					state_q     <= after_voice;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {samp_q[1], samp_q[0]};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/two_voice_sample_player_unit.sv @@
// Top level of the two-voice sample player: front end, command queue and back end.
// Depends on tvsp_pkg, tvsp_front and tvsp_back.
//
//  Channel  Dir  Beat contents
//  s_*      in   tuser: func; tdata: reg_offset, data_byte, rom_address
//  m_*      out  tdata: sample_a, sample_b (one beat per output tick)
//
// The front end takes one beat per cycle while its four-entry queue has room.
// The back end runs one queued command at a time against a single-port sample
// memory: a ROM load or select write is done in the idle state, a start makes two
// pointer-table reads, and an output tick makes up to two reads per voice.
// Reset clears all voice state; the sample memory holds garbage until loaded.
// A result waiting on m_tready stalls only the back end; the queue keeps filling.
module two_voice_sample_player_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // reg_offset[1:0], data_byte[9:2], rom_address[28:10], zero pad
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // sample_a[15:0], sample_b[31:16]
);

	// Queue head handed from the front end to the back end
	tvsp_pkg::q_head_t head;
	logic              pop;

	tvsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.pop      (pop),
		.head     (head)
	);

	tvsp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
